>>> hdl/sha256_message_digest_core_macros.svh
// assertion macros for the sha-256 core
`ifndef SHA256_MESSAGE_DIGEST_CORE_MACROS_SVH
`define SHA256_MESSAGE_DIGEST_CORE_MACROS_SVH
// property that must hold at every clock edge out of reset
`define SHA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`endif

>>> hdl/sha256_pkg.sv
// constants, types and round functions for the sha-256 core
package sha256_pkg;
	localparam int unsigned RoundCount = 64;
	localparam int unsigned BlockWords = 16;

	typedef logic [31:0] word_t;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// handshake between sequencer and round unit
	typedef struct packed {
		logic start;
		logic busy;
	} round_ctl_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

>>> hdl/sha256_message_digest_core.sv
// Byte-serial SHA-256 core. Each transfer carries at most one message byte and may
// end the message. A byte that does not fill a block is taken without a stall; the
// byte that fills a block then holds the input stalled through start, 64 rounds at one
// round per cycle, and write-back. Ending the message pads byte by byte at one byte per
// cycle, pausing while each full block (one or two blocks) is compressed, then
// emits eight digest words, h0 first, one per transfer.
`include "sha256_message_digest_core_macros.svh"
module sha256_message_digest_core import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        stall_in,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        valid_out,
	input  logic        stall_out,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	localparam logic [2:0] StIdle = 3'd0, StComp = 3'd1, StWait = 3'd2,
		StPad = 3'd3, StOut = 3'd4;

	logic [2:0]  st_q, ret_q;
	word_t       blk_q [16];
	word_t       h_q [8];
	word_t       hout [8];
	logic [63:0] bits_q, len_q;
	logic [5:0]  fill_q;
	logic        end_q, start;
	logic        len_blk_q;
	logic [2:0]  oidx_q;
	logic [7:0]  pbyte;
	round_ctl_t  ctl;

	sha256_round u_round (.clk, .arst_n, .start, .blk(blk_q), .hin(h_q), .hout, .ctl);

	assign stall_in    = (st_q != StIdle);
	assign valid_out   = (st_q == StOut);
	assign digest_word = h_q[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);
	assign start       = (st_q == StComp);

	always_comb begin
		// padding stream: marker, zeros, then length big-endian in the final block
		if (!end_q) pbyte = 8'h80;
		else if (len_blk_q && fill_q >= 6'd56) pbyte = len_q[8*(7-fill_q[2:0]) +: 8];
		else pbyte = 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= StIdle;
			ret_q     <= StIdle;
			fill_q    <= '0;
			bits_q    <= '0;
			len_q     <= '0;
			end_q     <= 1'b0;
			len_blk_q <= 1'b0;
			oidx_q    <= '0;
			h_q       <= InitHash;
			for (int i = 0; i < BlockWords; i++) blk_q[i] <= '0;
		end else begin
			unique case (st_q)
				StIdle: if (valid_in) begin
					if (byte_present) begin
						blk_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= data_byte;
						fill_q <= fill_q + 6'd1;
						bits_q <= bits_q + 64'd8;
					end
					if (message_end) begin
						len_q <= bits_q + (byte_present ? 64'd8 : 64'd0);
						end_q <= 1'b0;
						// marker lands before byte 56: the length fits in this block
						len_blk_q <= (fill_q + 6'(byte_present)) < 6'd56;
					end
					if (byte_present && fill_q == 6'd63) begin
						st_q  <= StComp;
						ret_q <= message_end ? StPad : StIdle;
					end else if (message_end) st_q <= StPad;
				end
				StComp: st_q <= StWait;
				StWait: if (!ctl.busy) begin
					h_q  <= hout;
					st_q <= ret_q;
				end
				StPad: begin
					blk_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= pbyte;
					fill_q <= fill_q + 6'd1;
					end_q  <= 1'b1;
					if (fill_q == 6'd63) begin
						st_q      <= StComp;
						ret_q     <= (end_q && len_blk_q) ? StOut : StPad;
						len_blk_q <= 1'b1;
					end
				end
				StOut: if (!stall_out) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						st_q   <= StIdle;
						h_q    <= InitHash;
						bits_q <= '0;
						fill_q <= '0;
						end_q  <= 1'b0;
						for (int i = 0; i < BlockWords; i++) blk_q[i] <= '0;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	`SHA_ASSERT(a_no_accept_busy, !(st_q != StIdle && !stall_in), "accept while busy")
	`SHA_ASSERT(a_round_only_wait, !ctl.busy || st_q == StWait, "round unit busy outside wait")
	`SHA_ASSERT(a_last_idx, !(valid_out && last_word) || word_index == 3'd7, "last word index")
endmodule

>>> hdl/sha256_round.sv
// single compression unit: rolling message schedule and one round per cycle
module sha256_round import sha256_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  word_t      blk [16],
	input  word_t      hin [8],
	output word_t      hout [8],
	output round_ctl_t ctl
);
	word_t      w_q [16];
	word_t      v_q [8];
	logic [5:0] rnd_q;
	logic       busy_q;
	word_t      s0, s1, wnew, t1, t2;

	always_comb begin
		s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		t1   = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + w_q[0];
		t2   = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		for (int i = 0; i < 8; i++) hout[i] = hin[i] + v_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
		end else if (busy_q) begin
			rnd_q <= rnd_q + 6'd1;
			if (rnd_q == 6'(RoundCount - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= blk;
			v_q <= hin;
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
endmodule
